### sv/sam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sam_pkg
// Shared types and constants for the saturating audio mixer: lane and
// pipeline payload layouts, register indexes and mix limits.
// ----------------------------------------------------------------------------
package sam_pkg;

	localparam int CHANNELS   = 4;
	localparam int SAMPLE_W   = 16;
	localparam int DIV_W      = 8;
	// one quotient bit per divider cell
	localparam int DIV_STEPS  = SAMPLE_W;
	localparam int STAGES     = DIV_STEPS + CHANNELS;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic signed [SAMPLE_W+1:0] MIX_HI = 18'sd32767;
	localparam logic signed [SAMPLE_W+1:0] MIX_LO = -18'sd32767;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHANNEL_ENABLE = 3'd0,
		REG_DIVISOR_CH0    = 3'd1,
		REG_DIVISOR_CH1    = 3'd2,
		REG_DIVISOR_CH2    = 3'd3,
		REG_DIVISOR_CH3    = 3'd4
	} reg_idx_t;

	// one channel inside the divider: sign, partial remainder, and a word that
	// shifts dividend bits out at the top and quotient bits in at the bottom
	typedef struct packed {
		logic                neg;
		logic [DIV_W-1:0]    rem;
		logic [SAMPLE_W-1:0] dq;
	} lane_t;

	typedef struct packed {
		lane_t [CHANNELS-1:0]       lane;
		logic signed [SAMPLE_W-1:0] acc;
		logic                       eob;
	} pipe_t;

endpackage

### sv/sam_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sam_div_cell
// One restoring-division step for every channel lane, registered, with an
// elastic valid/ready stage.
// ----------------------------------------------------------------------------
module sam_div_cell (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic [sam_pkg::CHANNELS-1:0][sam_pkg::DIV_W-1:0] divisor,
	input  logic                                           up_valid,
	output logic                                           up_ready,
	input  sam_pkg::pipe_t                                 up_data,
	output logic                                           dn_valid,
	input  logic                                           dn_ready,
	output sam_pkg::pipe_t                                 dn_data
);

	logic           valid_q;
	sam_pkg::pipe_t data_q;
	sam_pkg::pipe_t step;

	always_comb begin
		logic [sam_pkg::DIV_W:0] trial;
		logic [sam_pkg::DIV_W:0] diff;
		logic                    ge;
		step = up_data;
		for (int c = 0; c < sam_pkg::CHANNELS; c++) begin
			trial = {up_data.lane[c].rem, up_data.lane[c].dq[sam_pkg::SAMPLE_W-1]};
			diff  = trial - {1'b0, divisor[c]};
			ge    = (trial >= {1'b0, divisor[c]});
			step.lane[c].rem = ge ? diff[sam_pkg::DIV_W-1:0] : trial[sam_pkg::DIV_W-1:0];
			step.lane[c].dq  = {up_data.lane[c].dq[sam_pkg::SAMPLE_W-2:0], ge};
		end
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= step;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

### sv/sam_acc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sam_acc_cell
// Adds one channel's signed quotient to the running mix and clamps it when
// the channel is enabled, registered, with an elastic valid/ready stage.
// ----------------------------------------------------------------------------
module sam_acc_cell #(
	parameter int IDX = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           enable,
	input  logic           up_valid,
	output logic           up_ready,
	input  sam_pkg::pipe_t up_data,
	output logic           dn_valid,
	input  logic           dn_ready,
	output sam_pkg::pipe_t dn_data
);

	logic                                valid_q;
	sam_pkg::pipe_t                      data_q;
	sam_pkg::pipe_t                      step;
	logic signed [sam_pkg::SAMPLE_W:0]   mag;
	logic signed [sam_pkg::SAMPLE_W:0]   quot;
	logic signed [sam_pkg::SAMPLE_W+1:0] sum;

	always_comb begin
		mag  = $signed({1'b0, up_data.lane[IDX].dq});
		quot = up_data.lane[IDX].neg ? -mag : mag;
		sum  = 18'(up_data.acc) + 18'(quot);
		step = up_data;
		if (enable) begin
			if (sum > sam_pkg::MIX_HI) begin
				step.acc = sam_pkg::MIX_HI[sam_pkg::SAMPLE_W-1:0];
			end else if (sum < sam_pkg::MIX_LO) begin
				step.acc = sam_pkg::MIX_LO[sam_pkg::SAMPLE_W-1:0];
			end else begin
				step.acc = sum[sam_pkg::SAMPLE_W-1:0];
			end
		end
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= step;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

### sv/saturating_audio_mixer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saturating_audio_mixer_top
// Four-channel saturating mixer: divides each enabled sample by its volume
// divisor (truncating toward zero) and sums with a clamp to +/-32767.
// ----------------------------------------------------------------------------
// Usage: the block takes one item per cycle while the output side keeps up,
// and returns one mixed item per item, in order. Each item walks through a
// row of registered cells: sixteen divider cells (one quotient bit each, all
// four channels side by side on the magnitude of the sample) followed by four
// accumulate cells (one channel each, in channel order, with the clamp after
// every add). Every cell is an elastic stage, so a stalled output only fills
// the row; the input keeps accepting until all 20 cells hold an item. The last
// cell is the output register. Configuration writes are taken every cycle
// (cfg_ready is tied high) and must only be issued while the row is empty; a
// divisor of zero acts as one, and writes to indexes above 4 are dropped.
// ----------------------------------------------------------------------------
module saturating_audio_mixer_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// sample channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [sam_pkg::SAMPLE_W-1:0]   ch0_sample,
	input  logic signed [sam_pkg::SAMPLE_W-1:0]   ch1_sample,
	input  logic signed [sam_pkg::SAMPLE_W-1:0]   ch2_sample,
	input  logic signed [sam_pkg::SAMPLE_W-1:0]   ch3_sample,
	input  logic                                  end_of_block,
	// mixed channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [sam_pkg::SAMPLE_W-1:0]   mixed_sample,
	output logic                                  end_of_block_out,
	// configuration write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [sam_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [sam_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int N = sam_pkg::STAGES;

	logic [sam_pkg::CHANNELS-1:0]                      enable_q;
	logic [sam_pkg::CHANNELS-1:0][sam_pkg::DIV_W-1:0]  divisor_q;
	logic [sam_pkg::CHANNELS-1:0][sam_pkg::DIV_W-1:0]  divisor_eff;
	logic signed [sam_pkg::CHANNELS-1:0][sam_pkg::SAMPLE_W-1:0] samples;

	logic           pv [N+1];
	logic           pr [N+1];
	sam_pkg::pipe_t pd [N+1];

	// ---------------- configuration registers ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= '0;
			for (int c = 0; c < sam_pkg::CHANNELS; c++) begin
				divisor_q[c] <= sam_pkg::DIV_W'(1);
			end
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sam_pkg::REG_CHANNEL_ENABLE: enable_q     <= cfg_data[sam_pkg::CHANNELS-1:0];
				sam_pkg::REG_DIVISOR_CH0:    divisor_q[0] <= cfg_data;
				sam_pkg::REG_DIVISOR_CH1:    divisor_q[1] <= cfg_data;
				sam_pkg::REG_DIVISOR_CH2:    divisor_q[2] <= cfg_data;
				sam_pkg::REG_DIVISOR_CH3:    divisor_q[3] <= cfg_data;
				default: ;  // drop writes to unused indexes
			endcase
		end
	end

	// a zero divisor passes the sample undivided
	always_comb begin
		for (int c = 0; c < sam_pkg::CHANNELS; c++) begin
			divisor_eff[c] = (divisor_q[c] == '0) ? sam_pkg::DIV_W'(1) : divisor_q[c];
		end
	end

	// ---------------- entry: split each sample into sign and magnitude ----------------
	assign samples[0] = ch0_sample;
	assign samples[1] = ch1_sample;
	assign samples[2] = ch2_sample;
	assign samples[3] = ch3_sample;

	always_comb begin
		pd[0]     = '0;
		pd[0].eob = end_of_block;
		for (int c = 0; c < sam_pkg::CHANNELS; c++) begin
			pd[0].lane[c].neg = samples[c][sam_pkg::SAMPLE_W-1];
			pd[0].lane[c].rem = '0;
			// -32768 maps to magnitude 0x8000, which fits unsigned
			pd[0].lane[c].dq  = samples[c][sam_pkg::SAMPLE_W-1]
				? sam_pkg::SAMPLE_W'(~samples[c] + 1'b1) : samples[c];
		end
	end

	assign pv[0]    = in_valid;
	assign in_ready = pr[0];

	// ---------------- row of divider cells ----------------
	for (genvar k = 0; k < sam_pkg::DIV_STEPS; k++) begin : g_div
		sam_div_cell u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.divisor  (divisor_eff),
			.up_valid (pv[k]),
			.up_ready (pr[k]),
			.up_data  (pd[k]),
			.dn_valid (pv[k+1]),
			.dn_ready (pr[k+1]),
			.dn_data  (pd[k+1])
		);
	end

	// ---------------- row of accumulate cells, channel order ----------------
	for (genvar c = 0; c < sam_pkg::CHANNELS; c++) begin : g_acc
		sam_acc_cell #(
			.IDX (c)
		) u_acc (
			.clk      (clk),
			.arst_n   (arst_n),
			.enable   (enable_q[c]),
			.up_valid (pv[sam_pkg::DIV_STEPS+c]),
			.up_ready (pr[sam_pkg::DIV_STEPS+c]),
			.up_data  (pd[sam_pkg::DIV_STEPS+c]),
			.dn_valid (pv[sam_pkg::DIV_STEPS+c+1]),
			.dn_ready (pr[sam_pkg::DIV_STEPS+c+1]),
			.dn_data  (pd[sam_pkg::DIV_STEPS+c+1])
		);
	end

	// ---------------- output: the last cell is the output register ----------------
	assign out_valid        = pv[N];
	assign pr[N]            = out_ready;
	assign mixed_sample     = pd[N].acc;
	assign end_of_block_out = pd[N].eob;

endmodule

### sv/sam_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sam_checker
// Port-level checks for the saturating audio mixer, bound to the top level.
// ----------------------------------------------------------------------------
module sam_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [sam_pkg::SAMPLE_W-1:0] mixed_sample,
	input logic                                end_of_block_out,
	input logic                                cfg_valid,
	input logic                                cfg_ready
);

	// input backs up only when the output is stalled
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("in_ready low without a stalled output");

	// a stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable(mixed_sample) && $stable(end_of_block_out)))
		else $error("stalled output item changed");

	// the clamp never lets the most negative code through
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (mixed_sample != 16'sh8000))
		else $error("mixed_sample outside clamp range");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind saturating_audio_mixer_top sam_checker u_sam_checker (.*);

### bench/saturating_audio_mixer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saturating_audio_mixer_top_tb
// Self-checking bench for the four-channel saturating mixer. A scoreboard
// predicts each mixed item from the samples and the register settings it was
// accepted under. Every result is compared, in order, with that prediction.
// Stimulus is a short directed pass over the clamps, zero divisors, masking
// and ignored indexes, followed by random phases under changing settings,
// bursty input and a stalling output.
// ----------------------------------------------------------------------------

// one input item as the bench sees it
typedef struct packed {
	logic [sam_pkg::CHANNELS-1:0][sam_pkg::SAMPLE_W-1:0] ch;
	logic                                                eob;
} sample_item_t;

// one predicted result
typedef struct packed {
	logic signed [sam_pkg::SAMPLE_W-1:0] mix;
	logic                                eob;
} mix_result_t;

class mix_scoreboard;
	localparam int MAX_PRINTED = 40;

	logic [sam_pkg::CHANNELS-1:0] enable_mask;
	logic [sam_pkg::DIV_W-1:0]    divisor [sam_pkg::CHANNELS];
	mix_result_t                  expected_q [$];
	int                           errors;
	int                           n_inputs;
	int                           n_checked;
	int                           n_clamp_hi;
	int                           n_clamp_lo;
	int                           n_eob;
	int                           n_settings;

	function new();
		enable_mask = '0;
		foreach (divisor[i]) divisor[i] = 8'd1;
		errors     = 0;
		n_inputs   = 0;
		n_checked  = 0;
		n_clamp_hi = 0;
		n_clamp_lo = 0;
		n_eob      = 0;
		n_settings = 1;
	endfunction

	// mirror a register write; unknown indexes are dropped like the block does
	function void write_reg(logic [sam_pkg::CFG_IDX_W-1:0] idx,
				logic [sam_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			sam_pkg::REG_CHANNEL_ENABLE: enable_mask = data[sam_pkg::CHANNELS-1:0];
			sam_pkg::REG_DIVISOR_CH0:    divisor[0] = data;
			sam_pkg::REG_DIVISOR_CH1:    divisor[1] = data;
			sam_pkg::REG_DIVISOR_CH2:    divisor[2] = data;
			sam_pkg::REG_DIVISOR_CH3:    divisor[3] = data;
			default: ;
		endcase
	endfunction

	// divide each enabled sample, add in channel order, clamp after each add
	function mix_result_t mix_predict(sample_item_t it);
		mix_result_t r;
		int          acc;
		int          s;
		int          d;
		acc = 0;
		for (int i = 0; i < sam_pkg::CHANNELS; i++) begin
			if (enable_mask[i]) begin
				s = $signed(it.ch[i]);
				d = (divisor[i] == '0) ? 1 : int'(divisor[i]);
				acc = acc + s / d;
				if (acc > sam_pkg::MIX_HI)
					acc = sam_pkg::MIX_HI;
				else if (acc < sam_pkg::MIX_LO)
					acc = sam_pkg::MIX_LO;
			end
		end
		r.mix = acc[sam_pkg::SAMPLE_W-1:0];
		r.eob = it.eob;
		return r;
	endfunction

	function void note_input(sample_item_t it);
		mix_result_t r;
		r = mix_predict(it);
		expected_q.push_back(r);
		n_inputs++;
		if (r.mix == sam_pkg::MIX_HI) n_clamp_hi++;
		if (r.mix == sam_pkg::MIX_LO) n_clamp_lo++;
		if (r.eob) n_eob++;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	task report_mismatch(string what);
		errors++;
		if (errors <= MAX_PRINTED)
			$display("mismatch on result %0d: %s", n_checked, what);
	endtask

	task check_result(logic signed [sam_pkg::SAMPLE_W-1:0] mix, logic eob);
		mix_result_t want;
		if (expected_q.size() == 0) begin
			report_mismatch($sformatf("unexpected item mix=%0d eob=%0b", mix, eob));
		end else begin
			want = expected_q.pop_front();
			if (mix !== want.mix)
				report_mismatch($sformatf("mixed_sample %0d, want %0d", mix, want.mix));
			if (eob !== want.eob)
				report_mismatch($sformatf("end_of_block_out %0b, want %0b", eob, want.eob));
		end
		n_checked++;
	endtask
endclass

module saturating_audio_mixer_top_tb;
	import sam_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int TAIL_CYCLES   = STAGES + 10;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 115;

	// first index the block has no register for
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO = 3'd5;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_PATTERN,
		RX_HEAVY
	} rx_mode_t;

	logic                       clk          = 1'b0;
	logic                       arst_n       = 1'b0;
	logic                       in_valid     = 1'b0;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] ch0_s        = '0;
	logic signed [SAMPLE_W-1:0] ch1_s        = '0;
	logic signed [SAMPLE_W-1:0] ch2_s        = '0;
	logic signed [SAMPLE_W-1:0] ch3_s        = '0;
	logic                       eob_s        = 1'b0;
	logic                       out_valid;
	logic                       out_ready    = 1'b0;
	logic signed [SAMPLE_W-1:0] mixed_sample;
	logic                       end_of_block_out;
	logic                       cfg_valid    = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index    = '0;
	logic [CFG_DATA_W-1:0]      cfg_data     = '0;

	mix_scoreboard sb;
	int            cycle_count = 0;

	// sender idling: bursts of random length, gaps up to gap_max
	int            burst_left  = 0;
	int            gap_max     = 0;

	// receiver stall pattern, owned by the receiver process
	rx_mode_t      rx_mode     = RX_FREE;
	logic [15:0]   stall_pat   = 16'h00ff;
	logic [7:0]    rx_count    = '0;

	saturating_audio_mixer_top DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.ch0_sample       (ch0_s),
		.ch1_sample       (ch1_s),
		.ch2_sample       (ch2_s),
		.ch3_sample       (ch3_s),
		.end_of_block     (eob_s),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.mixed_sample     (mixed_sample),
		.end_of_block_out (end_of_block_out),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always #5 clk = ~clk;

	// end the run if the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d items still expected",
				cycle_count, sb.pending());
			$display("FAIL");
			$finish;
		end
	end

	// receiver: rotate the stall pattern every cycle, reload it now and then
	always @(posedge clk) begin
		rx_count <= rx_count + 8'd1;
		if (rx_count == '1)
			stall_pat <= 16'($urandom) | 16'h0001;
		else
			stall_pat <= {stall_pat[14:0], stall_pat[15]};
		case (rx_mode)
			RX_FREE:    out_ready <= 1'b1;
			RX_PATTERN: out_ready <= stall_pat[0];
			default:    out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// monitor: sample the output side on the edge that moves an item
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(mixed_sample, end_of_block_out);
	end

	// favor the clamp-relevant values, keep plenty of fully random words
	function automatic logic [SAMPLE_W-1:0] rand_sample();
		int v;
		case ($urandom_range(0, 7))
			0: v = 32767;
			1: v = -32768;
			2: v = 0;
			3: v = int'($urandom_range(0, 600)) - 300;
			default: v = int'($urandom);
		endcase
		return v[SAMPLE_W-1:0];
	endfunction

	// present one item, hold it until the block takes it, then note it
	task automatic send_item(input sample_item_t it);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			burst_left = $urandom_range(1, 32);
		end
		burst_left--;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		ch0_s    <= it.ch[0];
		ch1_s    <= it.ch[1];
		ch2_s    <= it.ch[2];
		ch3_s    <= it.ch[3];
		eob_s    <= it.eob;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(it);
	endtask

	task automatic send_vec(input int a, input int b, input int c, input int d,
				input logic eob);
		sample_item_t it;
		it.ch[0] = a[SAMPLE_W-1:0];
		it.ch[1] = b[SAMPLE_W-1:0];
		it.ch[2] = c[SAMPLE_W-1:0];
		it.ch[3] = d[SAMPLE_W-1:0];
		it.eob   = eob;
		send_item(it);
	endtask

	// drop valid and let every outstanding item come back
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// hold cfg_valid across back-to-back writes; the caller lowers it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
				 input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// reprogram every register with the row empty
	task automatic program_regs(input logic [CFG_DATA_W-1:0] en,
				    input logic [CFG_DATA_W-1:0] d0, input logic [CFG_DATA_W-1:0] d1,
				    input logic [CFG_DATA_W-1:0] d2, input logic [CFG_DATA_W-1:0] d3,
				    input bit poke_unused);
		wait_for_drain();
		write_reg(REG_DIVISOR_CH0, d0);
		write_reg(REG_DIVISOR_CH1, d1);
		write_reg(REG_DIVISOR_CH2, d2);
		write_reg(REG_DIVISOR_CH3, d3);
		write_reg(REG_CHANNEL_ENABLE, en);
		if (poke_unused)
			write_reg(CFG_IDX_UNUSED_LO + 3'($urandom_range(0, 2)), 8'($urandom));
		cfg_valid <= 1'b0;
		sb.n_settings++;
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_divisor();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd255;
			3: return 8'($urandom_range(2, 8));
			default: return 8'($urandom);
		endcase
	endfunction

	initial begin
		sample_item_t   it;
		logic [CFG_DATA_W-1:0] en;
		logic [CFG_DATA_W-1:0] dv [CHANNELS];

		sb = new();

		// hold reset low, then release it on an edge
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part: no idling on either side ---
		gap_max = 0;

		// reset settings: nothing enabled, so every mix is zero
		send_vec(32767, 32767, 32767, 32767, 1'b1);
		send_vec(-32768, -32768, -32768, -32768, 1'b0);

		// all channels on, unit divisors; upper data bits must be masked off
		program_regs(8'hff, 8'd1, 8'd1, 8'd1, 8'd1, 1'b0);
		send_vec(32767, 32767, 32767, 32767, 1'b0);
		send_vec(-32768, -32768, -32768, -32768, 1'b1);
		// most negative sample alone still lands on the lower clamp
		send_vec(-32768, 0, 0, 0, 1'b0);
		// clamp after every add, not once at the end
		send_vec(32767, 1, -1, 0, 1'b1);
		send_vec(-32768, -1, 1, 0, 1'b0);
		send_vec(0, 0, 0, 0, 1'b1);
		send_vec(16'h5555, 16'haaaa, 16'h00ff, 16'hff00, 1'b0);

		// zero divisor acts as one, large divisors, truncation toward zero;
		// the write to an unused index must leave everything alone
		program_regs(8'h0f, 8'd0, 8'd255, 8'd255, 8'd3, 1'b1);
		send_vec(-32768, 32767, -32768, -7, 1'b0);
		send_vec(7, -7, 254, -254, 1'b1);
		send_vec(-1, 1, -255, 255, 1'b0);
		send_vec(32767, 32767, 32767, 32767, 1'b1);

		// partial enables, in both interleavings
		program_regs(8'h05, 8'd2, 8'd1, 8'd7, 8'd1, 1'b0);
		send_vec(-5, 32767, 9, 32767, 1'b0);
		send_vec(32767, -32768, 32767, -32768, 1'b1);
		program_regs(8'hfa, 8'd1, 8'd2, 8'd1, 8'd255, 1'b1);
		send_vec(-5, -32767, 9, 32767, 1'b0);
		send_vec(32767, -32768, 32767, -32768, 1'b1);

		// --- random phases: new settings and idling style for each ---
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			en = 8'($urandom);
			foreach (dv[i]) dv[i] = pick_divisor();
			case (p)
				0: begin
					en[3:0] = 4'hf;
					foreach (dv[i]) dv[i] = 8'd1;
				end
				1: begin
					en[3:0] = 4'hf;
					foreach (dv[i]) dv[i] = 8'd255;
				end
				2: en[3:0] = 4'h0;
				3: begin
					en[3:0] = 4'hf;
					foreach (dv[i]) dv[i] = 8'd0;
				end
				default: if ($urandom_range(0, 2) == 0) en[3:0] = 4'hf;
			endcase
			program_regs(en, dv[0], dv[1], dv[2], dv[3], $urandom_range(0, 1));

			// first phase runs flat out; later ones add gaps, stalls or both
			gap_max    = (p % 4 == 0) ? 0 : $urandom_range(1, 12);
			burst_left = 0;
			rx_mode   <= (p == 0) ? RX_FREE : rx_mode_t'(p % 3);

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				for (int i = 0; i < CHANNELS; i++) it.ch[i] = rand_sample();
				it.eob = ($urandom_range(0, 7) == 0);
				send_item(it);
			end
		end

		// let the row empty, then watch a while for stray items
		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("mixed %0d items under %0d register settings, %0d results checked",
			sb.n_inputs, sb.n_settings, sb.n_checked);
		$display("upper clamp %0d, lower clamp %0d, end-of-block marks %0d, errors %0d",
			sb.n_clamp_hi, sb.n_clamp_lo, sb.n_eob, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
